// ----- sv/gdn_pkg.sv -----
// ----------------------------------------------------------------------------
// gdn_pkg: shared types and constants for the Gregorian day number converter
// Calendar cycle lengths, field widths, operation codes and the month table.
// ----------------------------------------------------------------------------
package gdn_pkg;

  localparam int YEAR_BITS      = 18;
  localparam int DN_BITS        = 27;
  localparam int DN_LIMIT       = 36500000;
  localparam int YEAR_LIMIT_MAX = 99999;

  localparam longint YEAR_POS_MAX = (longint'(1) << (YEAR_BITS - 1)) - 1;
  localparam longint YEAR_LIMIT   = (YEAR_POS_MAX < YEAR_LIMIT_MAX) ?
                                    YEAR_POS_MAX : YEAR_LIMIT_MAX;

  // days in 400, 100, 4 and 1 year cycles
  localparam int D400    = 400 * 365 + 400 / 4 - 400 / 100 + 400 / 400;
  localparam int D100    = 100 * 365 + 100 / 4 - 100 / 100;
  localparam int D4      = 4 * 365 + 4 / 4;
  localparam int D1      = 365;
  localparam int D1_LEAP = 366;

  // pipeline depth, input to output register
  localparam int NSTG = 9;

  // day of year width
  localparam int DOY_W = 9;

  typedef enum logic {
    OP_TO_DAYS = 1'b0,
    OP_TO_DATE = 1'b1
  } op_t;

  // days before the first of a month (month 1..12)
  function automatic logic [DOY_W-1:0] days_before(input logic leap,
                                                   input logic [3:0] month);
    logic [DOY_W-1:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = leap ? 9'd60  : 9'd59;
      4'd4:    d = leap ? 9'd91  : 9'd90;
      4'd5:    d = leap ? 9'd121 : 9'd120;
      4'd6:    d = leap ? 9'd152 : 9'd151;
      4'd7:    d = leap ? 9'd182 : 9'd181;
      4'd8:    d = leap ? 9'd213 : 9'd212;
      4'd9:    d = leap ? 9'd244 : 9'd243;
      4'd10:   d = leap ? 9'd274 : 9'd273;
      4'd11:   d = leap ? 9'd305 : 9'd304;
      4'd12:   d = leap ? 9'd335 : 9'd334;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

// ----- sv/gdn_pipe_ctl.sv -----
// ----------------------------------------------------------------------------
// gdn_pipe_ctl: valid tracking and stage enables for the converter pipeline
// Each stage loads when it is empty or the stage after it moves on.
// ----------------------------------------------------------------------------
module gdn_pipe_ctl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_op,
  output logic                      in_stall,
  output logic                      out_valid,
  output logic                      out_op,
  input  logic                      out_stall,
  output logic [gdn_pkg::NSTG-1:0]  en
);
  import gdn_pkg::*;

  logic [NSTG-1:0] v_r, v_nxt;
  logic [NSTG-1:0] op_r, op_nxt;

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    v_nxt  = v_r;
    op_nxt = op_r;
    if (en[0]) begin
      v_nxt[0]  = in_valid;
      op_nxt[0] = in_op;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        v_nxt[k]  = v_r[k-1];
        op_nxt[k] = op_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NSTG-1];
  assign out_op    = op_r[NSTG-1];

  // input is held back only when every stage holds a transaction
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled with an empty stage");

  // occupancy follows accepted minus delivered transactions
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(v_r) == $past($countones(v_r))
      + int'($past(in_valid && !in_stall)) - int'($past(out_valid && !out_stall))))
    else $error("pipeline occupancy mismatch");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0))
    else $error("pipeline not empty after reset");

  a_free_output: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

endmodule

// ----- sv/gdn_to_days.sv -----
// ----------------------------------------------------------------------------
// gdn_to_days: date to day number datapath
// Year minus one is biased by a multiple of 400 so all floor divisions are unsigned.
// ----------------------------------------------------------------------------
module gdn_to_days (
  input  logic                                clk,
  input  logic [gdn_pkg::NSTG-1:0]            en,
  input  logic [4:0]                          day_in,
  input  logic [3:0]                          month_in,
  input  logic signed [gdn_pkg::YEAR_BITS-1:0] year_in,
  output logic [gdn_pkg::DN_BITS-1:0]         dn,
  output logic                                err
);
  import gdn_pkg::*;

  localparam int     PW    = YEAR_BITS + 1;
  localparam longint OFF_B = ((longint'(1) << (YEAR_BITS - 1)) / 400) + 1;
  localparam longint OFF   = OFF_B * 400;
  localparam int     S25   = YEAR_BITS + 4;
  localparam longint M25   = ((longint'(1) << S25) + 24) / 25;
  localparam int     MW    = YEAR_BITS + 1;
  localparam int     HW    = YEAR_BITS - 4;
  localparam int     XW    = 2 * YEAR_BITS;
  localparam int     BW    = PW + 9;
  localparam int     NW    = (PW + 10 > DN_BITS + 2) ? PW + 10 : DN_BITS + 2;
  localparam longint C0    = OFF_B * D400;

  localparam logic signed [NW-1:0] N_HI = NW'(DN_LIMIT);
  localparam logic signed [NW-1:0] N_LO = NW'(-DN_LIMIT);
  localparam logic [MW-1:0]        M25_C = MW'(M25);

  // stage 1
  logic [PW-1:0]    p1_r, p1_nxt;
  logic [4:0]       d1_r;
  logic [3:0]       m1_r;
  // stage 2
  logic [PW-1:0]    p2_r;
  logic [HW-1:0]    h2_r, h2_nxt;
  logic [XW-1:0]    prod2;
  logic [4:0]       d2_r;
  logic [3:0]       m2_r;
  // stage 3
  logic [BW-1:0]    base3_r, base3_nxt;
  logic [HW-1:0]    hq3_r, hq3_nxt;
  logic [6:0]       rem3_r, rem3_nxt;
  logic [1:0]       hlo3_r, plo3_r;
  logic [4:0]       d3_r;
  logic [3:0]       m3_r;
  // stage 4
  logic             leap4;
  logic [NW-1:0]    n4_r, n4_nxt;
  logic [DOY_W-1:0] bd4_r, bd4_nxt;
  logic             bad4_r, bad4_nxt;
  // stage 5
  logic [NW-1:0]    n5_r, n5_nxt;
  logic             bad5_r;
  // stage 6 and carry stages
  logic [DN_BITS-1:0] dn6_r, dn6_nxt, dn7_r, dn8_r, dn9_r;
  logic               err6_r, err6_nxt, err7_r, err8_r, err9_r;

  assign p1_nxt = {year_in[YEAR_BITS-1], year_in} + PW'(OFF - 1);

  // floor(p/100) via reciprocal of 25 on p/4
  assign prod2  = XW'(p1_r[PW-1:2]) * XW'(M25_C);
  assign h2_nxt = prod2[S25 +: HW];

  assign base3_nxt = BW'(p2_r) * BW'(365) + BW'(p2_r[PW-1:2]);
  assign hq3_nxt   = h2_r - (h2_r >> 2);
  // p mod 100; exact in 7 bits
  assign rem3_nxt  = p2_r[6:0] - 7'(h2_r[6:0] * 7'd100);

  // year = p + 1 - OFF and OFF is a multiple of 400
  assign leap4    = (plo3_r == 2'd3) && ((rem3_r != 7'd99) || (hlo3_r == 2'd3));
  assign bd4_nxt  = days_before(leap4, m3_r) + DOY_W'(d3_r);
  assign n4_nxt   = NW'(base3_r) - NW'(hq3_r) - NW'(C0);
  assign bad4_nxt = (m3_r == 4'd0) || (m3_r > 4'd12);

  assign n5_nxt   = n4_r + NW'(bd4_r);

  assign err6_nxt = bad5_r || ($signed(n5_r) < N_LO) || ($signed(n5_r) > N_HI);
  assign dn6_nxt  = bad5_r ? '0 : n5_r[DN_BITS-1:0];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1_r <= p1_nxt;
      d1_r <= day_in;
      m1_r <= month_in;
    end
    if (en[1]) begin
      p2_r <= p1_r;
      h2_r <= h2_nxt;
      d2_r <= d1_r;
      m2_r <= m1_r;
    end
    if (en[2]) begin
      base3_r <= base3_nxt;
      hq3_r   <= hq3_nxt;
      rem3_r  <= rem3_nxt;
      hlo3_r  <= h2_r[1:0];
      plo3_r  <= p2_r[1:0];
      d3_r    <= d2_r;
      m3_r    <= m2_r;
    end
    if (en[3]) begin
      n4_r   <= n4_nxt;
      bd4_r  <= bd4_nxt;
      bad4_r <= bad4_nxt;
    end
    if (en[4]) begin
      n5_r   <= n5_nxt;
      bad5_r <= bad4_r;
    end
    if (en[5]) begin
      dn6_r  <= dn6_nxt;
      err6_r <= err6_nxt;
    end
    if (en[6]) begin
      dn7_r  <= dn6_r;
      err7_r <= err6_r;
    end
    if (en[7]) begin
      dn8_r  <= dn7_r;
      err8_r <= err7_r;
    end
    if (en[8]) begin
      dn9_r  <= dn8_r;
      err9_r <= err8_r;
    end
  end

  assign dn  = dn9_r;
  assign err = err9_r;

endmodule

// ----- sv/gdn_from_days.sv -----
// ----------------------------------------------------------------------------
// gdn_from_days: day number to date datapath
// Splits the magnitude into 400/100/4/1 year cycles, then searches months.
// ----------------------------------------------------------------------------
module gdn_from_days (
  input  logic                                 clk,
  input  logic [gdn_pkg::NSTG-1:0]             en,
  input  logic signed [gdn_pkg::DN_BITS-1:0]   dn_in,
  output logic [4:0]                           day,
  output logic [3:0]                           month,
  output logic signed [gdn_pkg::YEAR_BITS-1:0] year,
  output logic                                 err
);
  import gdn_pkg::*;

  localparam int     AW    = DN_BITS;
  localparam int     R4W   = $clog2(D400);
  localparam int     S400  = DN_BITS - 1 + R4W;
  localparam longint M400  = ((longint'(1) << S400) + D400 - 1) / D400;
  localparam int     M4W   = $clog2(M400 + 1);
  localparam int     PRW   = AW + M4W;
  localparam int     Q4W   = $clog2(((longint'(1) << (DN_BITS - 1)) / D400) + 1);
  localparam int     R1W   = $clog2(D100 + 1);
  localparam int     R3W   = $clog2(D4);
  localparam int     S1461 = R1W + R3W;
  localparam longint M1461 = ((longint'(1) << S1461) + D4 - 1) / D4;
  localparam int     MQW   = $clog2(M1461 + 1);
  localparam int     P2W   = R1W + MQW;
  localparam int     QW4   = $clog2(D100 / D4 + 1);
  localparam int     YMW   = $clog2(((longint'(1) << (DN_BITS - 1)) / D1) + 2);
  localparam int     YSW   = YMW + 1;

  // stage 1: magnitude
  logic [AW-1:0]    dn_u, a1_r, a1_nxt;
  logic             neg1_r;
  // stage 2: 400 year count
  logic [PRW-1:0]   prod2;
  logic [Q4W-1:0]   q2_r;
  logic [AW-1:0]    a2_r;
  logic             neg2_r;
  // stage 3
  logic [R4W-1:0]   r3_r, r3_nxt;
  logic [YMW-1:0]   y3_r, y3_nxt;
  logic             neg3_r;
  // stage 4: century count
  logic [1:0]       q100;
  logic [R1W-1:0]   r4_r, r4_nxt;
  logic [YMW-1:0]   y4_r, y4_nxt;
  logic             c3_4_r, neg4_r;
  // stage 5: 4 year count
  logic [P2W-1:0]   prod5;
  logic [QW4-1:0]   q5_r;
  logic [R1W-1:0]   r5_r;
  logic [YMW-1:0]   y5_r;
  logic             c3_5_r, neg5_r;
  // stage 6
  logic [R3W-1:0]   r6_r, r6_nxt;
  logic [YMW-1:0]   y6_r, y6_nxt;
  logic             c24_6_r, c24_6_nxt, neg6_r;
  // stage 7: single years
  logic [1:0]       q1;
  logic [DOY_W-1:0] a7_r, a7_nxt;
  logic [YMW-1:0]   y7_r, y7_nxt;
  logic             leap7_r, leap7_nxt, neg7_r;
  // stage 8: mirror
  logic [DOY_W-1:0] len8, doy8_r, doy8_nxt;
  logic [YMW-1:0]   y8_r;
  logic             leap8_r, neg8_r;
  // stage 9: month search and output
  logic [4:0]            day9_r, day9_nxt;
  logic [3:0]            mon9_r, mon9_nxt;
  logic signed [YSW-1:0] ys;
  logic [YEAR_BITS-1:0]  year9_r, year9_nxt;
  logic                  err9_r, err9_nxt;

  assign dn_u   = dn_in;
  assign a1_nxt = dn_u[AW-1] ? (AW'(0) - dn_u) : dn_u;

  assign prod2  = PRW'(a1_r) * PRW'(M400);

  assign r3_nxt = R4W'(a2_r - AW'(q2_r) * AW'(D400));
  assign y3_nxt = YMW'(q2_r) * YMW'(400);

  // century count capped at 3 keeps the last day of a 400 year cycle
  always_comb begin
    if (r3_r >= R4W'(3 * D100)) begin
      q100 = 2'd3;
    end else if (r3_r >= R4W'(2 * D100)) begin
      q100 = 2'd2;
    end else if (r3_r >= R4W'(D100)) begin
      q100 = 2'd1;
    end else begin
      q100 = 2'd0;
    end
  end

  assign r4_nxt = R1W'(r3_r - R4W'(q100) * R4W'(D100));
  assign y4_nxt = y3_r + YMW'(q100) * YMW'(100);

  assign prod5  = P2W'(r4_r) * P2W'(M1461);

  assign r6_nxt    = R3W'(r5_r - R1W'(q5_r) * R1W'(D4));
  assign y6_nxt    = y5_r + YMW'({q5_r, 2'b00});
  // year lands on a century that is not a multiple of 400
  assign c24_6_nxt = (q5_r == QW4'(24)) && !c3_5_r;

  always_comb begin
    if (r6_r >= R3W'(3 * D1)) begin
      q1 = 2'd3;
    end else if (r6_r >= R3W'(2 * D1)) begin
      q1 = 2'd2;
    end else if (r6_r >= R3W'(D1)) begin
      q1 = 2'd1;
    end else begin
      q1 = 2'd0;
    end
  end

  assign a7_nxt    = DOY_W'(r6_r - R3W'(q1) * R3W'(D1));
  assign y7_nxt    = y6_r + YMW'(q1) + YMW'(a7_nxt != '0);
  assign leap7_nxt = (q1 == 2'd3) && !c24_6_r;

  assign len8     = leap7_r ? DOY_W'(D1_LEAP) : DOY_W'(D1);
  assign doy8_nxt = (a7_r == '0) ? '0 : (neg7_r ? (len8 - a7_r) : a7_r);

  // zero day of year stays 31 December
  always_comb begin
    mon9_nxt = 4'd12;
    day9_nxt = 5'd31;
    for (int i = 1; i <= 12; i++) begin
      if (doy8_r > days_before(leap8_r, 4'(i))) begin
        mon9_nxt = 4'(i);
        day9_nxt = 5'(doy8_r - days_before(leap8_r, 4'(i)));
      end
    end
  end

  assign ys        = neg8_r ? (YSW'(0) - {1'b0, y8_r}) : {1'b0, y8_r};
  assign year9_nxt = YEAR_BITS'(ys);
  assign err9_nxt  = y8_r > YMW'(YEAR_LIMIT);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a1_r   <= a1_nxt;
      neg1_r <= dn_u[AW-1];
    end
    if (en[1]) begin
      q2_r   <= prod2[S400 +: Q4W];
      a2_r   <= a1_r;
      neg2_r <= neg1_r;
    end
    if (en[2]) begin
      r3_r   <= r3_nxt;
      y3_r   <= y3_nxt;
      neg3_r <= neg2_r;
    end
    if (en[3]) begin
      r4_r   <= r4_nxt;
      y4_r   <= y4_nxt;
      c3_4_r <= (q100 == 2'd3);
      neg4_r <= neg3_r;
    end
    if (en[4]) begin
      q5_r   <= prod5[S1461 +: QW4];
      r5_r   <= r4_r;
      y5_r   <= y4_r;
      c3_5_r <= c3_4_r;
      neg5_r <= neg4_r;
    end
    if (en[5]) begin
      r6_r    <= r6_nxt;
      y6_r    <= y6_nxt;
      c24_6_r <= c24_6_nxt;
      neg6_r  <= neg5_r;
    end
    if (en[6]) begin
      a7_r    <= a7_nxt;
      y7_r    <= y7_nxt;
      leap7_r <= leap7_nxt;
      neg7_r  <= neg6_r;
    end
    if (en[7]) begin
      doy8_r  <= doy8_nxt;
      y8_r    <= y7_r;
      leap8_r <= leap7_r;
      neg8_r  <= neg7_r;
    end
    if (en[8]) begin
      day9_r  <= day9_nxt;
      mon9_r  <= mon9_nxt;
      year9_r <= year9_nxt;
      err9_r  <= err9_nxt;
    end
  end

  assign day   = day9_r;
  assign month = mon9_r;
  assign year  = $signed(year9_r);
  assign err   = err9_r;

endmodule

// ----- sv/gregorian_day_number_converter.sv -----
// ----------------------------------------------------------------------------
// gregorian_day_number_converter: proleptic Gregorian date <-> day number
// Day number 1 is 1 January of year 1; negative day numbers are mirrored.
//
//   channel   ports                                             direction
//   in        in_valid, in_stall, in_op, in_day_in, in_month_in,  to block
//             in_year_in, in_day_number_in
//   out       out_valid, out_stall, out_day_number_out,          from block
//             out_day_out, out_month_out, out_year_out,
//             out_range_error
//
// One transaction per cycle unless in_stall holds the input. The depth is set
// by the nine register stages of the day number to date path; the date to
// day number path is padded to the same depth.
// Reset clears the stage valid bits only.
// A stall on the output holds the last stage; earlier stages keep moving
// into empty slots, so in_stall rises only when every stage is occupied.
// ----------------------------------------------------------------------------
module gregorian_day_number_converter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [4:0]                           in_day_in,
  input  logic [3:0]                           in_month_in,
  input  logic signed [gdn_pkg::YEAR_BITS-1:0] in_year_in,
  input  logic signed [gdn_pkg::DN_BITS-1:0]   in_day_number_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [gdn_pkg::DN_BITS-1:0]   out_day_number_out,
  output logic [4:0]                           out_day_out,
  output logic [3:0]                           out_month_out,
  output logic signed [gdn_pkg::YEAR_BITS-1:0] out_year_out,
  output logic                                 out_range_error
);
  import gdn_pkg::*;

  logic [NSTG-1:0]             en;
  logic                        out_op;
  logic [DN_BITS-1:0]          dn;
  logic                        err_days;
  logic [4:0]                  day;
  logic [3:0]                  month;
  logic signed [YEAR_BITS-1:0] year;
  logic                        err_date;
  logic                        is_date;

  gdn_pipe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_op    (out_op),
    .out_stall (out_stall),
    .en        (en)
  );

  gdn_to_days u_to_days (
    .clk      (clk),
    .en       (en),
    .day_in   (in_day_in),
    .month_in (in_month_in),
    .year_in  (in_year_in),
    .dn       (dn),
    .err      (err_days)
  );

  gdn_from_days u_from_days (
    .clk   (clk),
    .en    (en),
    .dn_in (in_day_number_in),
    .day   (day),
    .month (month),
    .year  (year),
    .err   (err_date)
  );

  // unused fields of the other direction read as zero
  assign is_date            = (out_op == OP_TO_DATE);
  assign out_day_number_out = is_date ? '0 : $signed(dn);
  assign out_day_out        = is_date ? day : '0;
  assign out_month_out      = is_date ? month : '0;
  assign out_year_out       = is_date ? year : '0;
  assign out_range_error    = is_date ? err_date : err_days;

endmodule
